@@ design/tt_pkg.sv @@
package tt_pkg;

    localparam int INDEX_BITS = 16;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 32;
    localparam int KIND_W  = 2;

    // s_axis_tdata layout, lowest bit first
    localparam int IN_KEY_LSB   = 0;
    localparam int IN_DEPTH_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_SCORE_LSB = IN_DEPTH_LSB + DEPTH_W;
    localparam int IN_KIND_LSB  = IN_SCORE_LSB + SCORE_W;
    localparam int IN_ALPHA_LSB = IN_KIND_LSB + KIND_W;
    localparam int IN_BETA_LSB  = IN_ALPHA_LSB + SCORE_W;
    localparam int IN_USED_W    = IN_BETA_LSB + SCORE_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_TDATA_W  = SCORE_W;
    localparam int OUT_TUSER_W  = 2;
    localparam int OUT_HIT_BIT  = 0;
    localparam int OUT_WR_BIT   = 1;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;
    // stored like any other kind, never gives a hit
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ design/tt_ram.sv @@
module tt_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [(1 << ADDR_BITS)];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/transposition_table_probe_store.sv @@
// An accepted input beat is registered together with its RAM read; its result then goes
// into the output register once that register is free or being taken. One item is in flight
// at a time: the single RAM port pair does a read, then for a store a write-back, per item.
// An input beat may be taken while the previous result still waits in the output register.
// Reset (synchronous, active low) starts a sweep that writes all 2**INDEX_BITS entries
// (65536 at the default) empty, during which s_axis_tready stays low.
module transposition_table_probe_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key, depth, score, bound_kind, alpha, beta; zero pad to the top
    input  logic [tt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value
    output logic [tt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // hit, written
    output logic [tt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    localparam int IB = tt_pkg::INDEX_BITS;

    logic                         r_clr;
    logic [IB-1:0]                r_clr_addr;
    logic                         r_busy;

    logic                         r_action;
    logic [tt_pkg::KEY_W-1:0]     r_key;
    logic [tt_pkg::DEPTH_W-1:0]   r_depth;
    logic [tt_pkg::SCORE_W-1:0]   r_score;
    logic [tt_pkg::KIND_W-1:0]    r_kind;
    logic [tt_pkg::SCORE_W-1:0]   r_alpha;
    logic [tt_pkg::SCORE_W-1:0]   r_beta;

    logic                         r_out_valid;
    logic                         r_out_hit;
    logic                         r_out_written;
    logic [tt_pkg::SCORE_W-1:0]   r_out_value;

    tt_pkg::t_entry               rd_entry;
    logic [tt_pkg::ENTRY_W-1:0]   rd_word;
    tt_pkg::t_entry               wr_entry;
    logic                         ram_we;
    logic [IB-1:0]                ram_waddr;

    logic                         in_acc;
    logic                         done;
    logic                         store_ok;
    logic                         n_hit;
    logic [tt_pkg::SCORE_W-1:0]   n_value;
    logic                         key_match;

    assign s_axis_tready = !r_busy && !r_clr;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign done          = r_busy && (!r_out_valid || m_axis_tready);

    assign rd_entry = tt_pkg::t_entry'(rd_word);

    // read data stays put while busy since no new read is issued
    always_comb begin
        store_ok  = !(rd_entry.valid && (rd_entry.depth > r_depth));
        key_match = rd_entry.valid && (rd_entry.key == r_key) && (rd_entry.depth >= r_depth);
        n_hit     = 1'b0;
        n_value   = '0;
        if (r_action == tt_pkg::ACT_PROBE && key_match) begin
            unique case (rd_entry.kind)
                tt_pkg::KIND_EXACT: begin
                    n_hit   = 1'b1;
                    n_value = rd_entry.score;
                end
                tt_pkg::KIND_UPPER: begin
                    if ($signed(rd_entry.score) <= $signed(r_alpha)) begin
                        n_hit   = 1'b1;
                        n_value = r_alpha;
                    end
                end
                tt_pkg::KIND_LOWER: begin
                    if ($signed(rd_entry.score) >= $signed(r_beta)) begin
                        n_hit   = 1'b1;
                        n_value = r_beta;
                    end
                end
                default: begin
                    n_hit   = 1'b0;
                    n_value = '0;
                end
            endcase
        end
    end

    always_comb begin
        if (r_clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            wr_entry  = '0;
        end else begin
            ram_we         = done && (r_action == tt_pkg::ACT_STORE) && store_ok;
            ram_waddr      = r_key[IB-1:0];
            wr_entry.valid = 1'b1;
            wr_entry.kind  = r_kind;
            wr_entry.depth = r_depth;
            wr_entry.score = r_score;
            wr_entry.key   = r_key;
        end
    end

    tt_ram #(
        .WIDTH     (tt_pkg::ENTRY_W),
        .ADDR_BITS (IB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (in_acc),
        .i_raddr (s_axis_tdata[tt_pkg::IN_KEY_LSB +: IB]),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clr <= 1'b0;
                end
            end
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= s_axis_tuser;
            r_key    <= s_axis_tdata[tt_pkg::IN_KEY_LSB   +: tt_pkg::KEY_W];
            r_depth  <= s_axis_tdata[tt_pkg::IN_DEPTH_LSB +: tt_pkg::DEPTH_W];
            r_score  <= s_axis_tdata[tt_pkg::IN_SCORE_LSB +: tt_pkg::SCORE_W];
            r_kind   <= s_axis_tdata[tt_pkg::IN_KIND_LSB  +: tt_pkg::KIND_W];
            r_alpha  <= s_axis_tdata[tt_pkg::IN_ALPHA_LSB +: tt_pkg::SCORE_W];
            r_beta   <= s_axis_tdata[tt_pkg::IN_BETA_LSB  +: tt_pkg::SCORE_W];
        end
        if (done) begin
            r_out_hit     <= n_hit;
            r_out_value   <= n_value;
            r_out_written <= (r_action == tt_pkg::ACT_STORE) && store_ok;
        end
    end

    assign m_axis_tvalid                      = r_out_valid;
    assign m_axis_tdata                       = r_out_value;
    assign m_axis_tuser[tt_pkg::OUT_HIT_BIT]  = r_out_hit;
    assign m_axis_tuser[tt_pkg::OUT_WR_BIT]   = r_out_written;

    a_no_item_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !r_busy)
        else $error("item in flight during clearing sweep");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_busy && !s_axis_tready))
        else $error("accepted beat did not block the input");

    a_hit_xor_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_written))
        else $error("result flags both hit and written");

    a_miss_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == '0))
        else $error("miss carries a nonzero value");

    a_done_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && !r_busy))
        else $error("finished item did not reach the output register");

endmodule
